FILE: src/psdir_pkg.sv
// ----------------------------------------------------------------------------
// psdir_pkg
// shared types, constants and the period table of the pitch shift resampler
// ----------------------------------------------------------------------------
package psdir_pkg;

   localparam int SampleWidth = 24;
   localparam int BlockLen    = 20;
   localparam int ShiftWidth  = 6;
   localparam int PhaseWidth  = 5;
   localparam int QueueDepth  = 4;
   localparam int QueuePtrW   = $clog2(QueueDepth);
   localparam int QueueCntW   = $clog2(QueueDepth + 1);

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic signed [ShiftWidth-1:0]  shift_type;
   typedef logic [PhaseWidth-1:0]         phase_type;

   typedef struct packed {
      logic signed [SampleWidth-1:0] sample_in;
      logic                          end_of_stream;
   } req_type;

   typedef struct packed {
      logic signed [SampleWidth-1:0] sample_out;
      logic                          run_last;
   } rsp_type;

   // one classified input word: optional insert, then optional kept sample
   typedef struct packed {
      logic       has_ins;
      sample_type ins_sample;
      logic       has_keep;
      sample_type keep_sample;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // samples between drops or inserts for a shift magnitude, block of 20
   function automatic phase_type period_of(input logic [ShiftWidth-1:0] mag);
      phase_type p;
      case (mag)
         ShiftWidth'(1): p = PhaseWidth'(20);
         ShiftWidth'(2): p = PhaseWidth'(10);
         ShiftWidth'(3): p = PhaseWidth'(6);
         ShiftWidth'(4): p = PhaseWidth'(5);
         ShiftWidth'(5): p = PhaseWidth'(4);
         ShiftWidth'(6): p = PhaseWidth'(3);
         ShiftWidth'(7), ShiftWidth'(8), ShiftWidth'(9), ShiftWidth'(10): begin
            p = PhaseWidth'(2);
         end
         default: p = PhaseWidth'(1);
      endcase
      return p;
   endfunction

endpackage

FILE: src/psdir_front.sv
// ----------------------------------------------------------------------------
// psdir_front
// holds shift and phase state, classifies each input word into an entry
// ----------------------------------------------------------------------------
module psdir_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  psdir_pkg::shift_type    csr_data,
   input  logic                    accept,
   input  psdir_pkg::req_type      req_data,
   output logic                    push,
   output psdir_pkg::entry_type    entry
);

   psdir_pkg::shift_type  shift_ff, shift_in;
   psdir_pkg::phase_type  phase_ff, phase_in;
   psdir_pkg::sample_type held_ff, held_in;
   logic                  pend_ff, pend_in;

   logic [psdir_pkg::ShiftWidth-1:0] mag;
   logic [psdir_pkg::ShiftWidth-1:0] thr;
   psdir_pkg::phase_type             period;
   logic [psdir_pkg::PhaseWidth:0]   phase_inc;
   logic                             keep;
   logic                             want_ins;
   logic                             advance;
   logic signed [psdir_pkg::SampleWidth:0] sum;

   always_comb begin
      mag       = psdir_pkg::ShiftWidth'(-shift_ff);
      thr       = psdir_pkg::ShiftWidth'(psdir_pkg::BlockLen) -
                  psdir_pkg::ShiftWidth'(2 * (10 - shift_ff));
      phase_inc = {1'b0, phase_ff} + 1'b1;
      sum       = {held_ff[psdir_pkg::SampleWidth-1], held_ff} +
                  {req_data.sample_in[psdir_pkg::SampleWidth-1], req_data.sample_in};
      keep      = 1'b0;
      want_ins  = 1'b0;
      advance   = 1'b0;
      period    = psdir_pkg::PhaseWidth'(psdir_pkg::BlockLen);
      if (shift_ff > 6'sd10) begin
         keep = 1'b0;
      end else if (shift_ff == 6'sd0) begin
         keep = 1'b1;
      end else if (shift_ff >= 6'sd7) begin
         keep    = ({1'b0, phase_ff} >= thr) || !phase_ff[0];
         advance = 1'b1;
      end else if (shift_ff > 6'sd0) begin
         period  = psdir_pkg::period_of(psdir_pkg::ShiftWidth'(shift_ff));
         keep    = (phase_ff != '0);
         advance = 1'b1;
      end else begin
         period   = psdir_pkg::period_of(mag);
         keep     = 1'b1;
         want_ins = (phase_inc >= {1'b0, period});
         advance  = 1'b1;
      end

      entry.has_ins     = pend_ff;
      entry.ins_sample  = sum[psdir_pkg::SampleWidth:1];
      entry.has_keep    = keep;
      entry.keep_sample = req_data.sample_in;
      push              = accept && (pend_ff || keep);

      shift_in = csr_valid ? csr_data : shift_ff;
      phase_in = phase_ff;
      held_in  = held_ff;
      pend_in  = pend_ff;
      if (accept) begin
         pend_in = 1'b0;
         if (advance) begin
            phase_in = (phase_inc >= {1'b0, period}) ? '0 :
                       phase_inc[psdir_pkg::PhaseWidth-1:0];
         end
         if (want_ins && !req_data.end_of_stream) begin
            pend_in = 1'b1;
            held_in = req_data.sample_in;
         end
         if (req_data.end_of_stream) begin
            phase_in = '0;
            pend_in  = 1'b0;
            held_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         phase_ff <= '0;
         held_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         phase_ff <= phase_in;
         held_ff  <= held_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

FILE: src/psdir_queue.sv
// ----------------------------------------------------------------------------
// psdir_queue
// short entry queue between the classifier and the emitter
// ----------------------------------------------------------------------------
module psdir_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  psdir_pkg::entry_type        push_entry,
   input  logic                        pop,
   output psdir_pkg::entry_type        head,
   output psdir_pkg::q_status_type     status
);

   psdir_pkg::entry_type                  slot_ff [psdir_pkg::QueueDepth];
   logic [psdir_pkg::QueuePtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [psdir_pkg::QueuePtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [psdir_pkg::QueueCntW-1:0]       count_ff, count_in;

   always_comb begin
      status.full  = (count_ff == psdir_pkg::QueueCntW'(psdir_pkg::QueueDepth));
      status.empty = (count_ff == '0);
      head         = slot_ff[rd_ptr_ff];
      wr_ptr_in    = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in     = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: src/psdir_back.sv
// ----------------------------------------------------------------------------
// psdir_back
// emits the insert and kept sample of each entry through an output register
// ----------------------------------------------------------------------------
module psdir_back (
   input  logic                        clock,
   input  logic                        reset,
   input  psdir_pkg::entry_type        head,
   input  psdir_pkg::q_status_type     status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output psdir_pkg::rsp_type          rsp_data
);

   logic               valid_ff, valid_in;
   psdir_pkg::rsp_type data_ff, data_in;
   logic               ins_done_ff, ins_done_in;
   logic               load;

   always_comb begin
      load        = (!valid_ff || !rsp_stall) && !status.empty;
      valid_in    = valid_ff && rsp_stall;
      data_in     = data_ff;
      ins_done_in = ins_done_ff;
      pop         = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (head.has_ins && !ins_done_ff) begin
            data_in.sample_out = head.ins_sample;
            data_in.run_last   = !head.has_keep;
            if (head.has_keep) begin
               ins_done_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            data_in.sample_out = head.keep_sample;
            data_in.run_last   = 1'b1;
            ins_done_in        = 1'b0;
            pop                = 1'b1;
         end
      end
      rsp_valid = valid_ff;
      rsp_data  = data_ff;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         ins_done_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         ins_done_ff <= ins_done_in;
      end
   end

endmodule

FILE: src/pitch_shift_drop_insert_resampler.sv
// ----------------------------------------------------------------------------
// pitch_shift_drop_insert_resampler
// drop/insert resampler for a crude pitch shift of 24-bit audio
//
// req channel: one sample word per handshake (valid high, stall low), with an
// end_of_stream flag on the final sample. rsp channel: zero, one or two words
// per input, run_last high on the last word an input produced.
// csr channel: writes the 6-bit signed shift; always ready. the user must see that it is
// written only while no word is in flight; the block does not enforce this.
// the front classifies a word in the cycle it is taken, a four-entry queue
// holds classified words, the back emits one result word per cycle while
// rsp_stall is low through an output register. an accepted word is written
// into the queue and its first result is then loaded into that register.
// an input word is taken every cycle while the queue has room; sustained
// throughput is one result word per cycle while rsp_stall is low.
// reset clears shift, phase, pending insert, queue and output valid.
// when rsp_stall is high the output word holds, the queue fills, and
// req_stall rises once all four entries are taken.
// ----------------------------------------------------------------------------
module pitch_shift_drop_insert_resampler (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  psdir_pkg::req_type       req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output psdir_pkg::rsp_type       rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  psdir_pkg::shift_type     csr_data
);

   psdir_pkg::entry_type    entry;
   psdir_pkg::entry_type    head;
   psdir_pkg::q_status_type status;
   logic                    accept;
   logic                    push;
   logic                    pop;

   assign req_stall = status.full;
   assign accept    = req_valid && !status.full;
   assign csr_ready = 1'b1;

   psdir_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .accept    (accept),
      .req_data  (req_data),
      .push      (push),
      .entry     (entry)
   );

   psdir_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   psdir_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
